/* src/lease_credit_allocator_unit_assert.svh */
// assertion macros for the lease credit allocator
// used by the top level only, no other dependencies
`ifndef LEASE_CREDIT_ALLOCATOR_UNIT_ASSERT_SVH
`define LEASE_CREDIT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LCAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LCAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lcau_pkg.sv */
// shared constants and types for the lease credit allocator
// no dependencies
package lcau_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int STAMP_W   = 32;
    localparam int CRED_W    = 11;
    localparam int SLOT_W    = 10;
    localparam int LIM_W     = ((IDX_W + 1) > CRED_W) ? (IDX_W + 1) : CRED_W;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECLAIM  = 2'd2;

    localparam logic [CRED_W-1:0]  CREDITS_RST = 11'd64;
    localparam logic [STAMP_W-1:0] RECLAIM_RST = 32'd8;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // control into the slot ring
    typedef struct packed {
        logic               shift;
        logic               wr;
        logic [STAMP_W-1:0] data;
    } t_ring_ctl;

endpackage

/* src/lcau_cell.sv */
// one slot cell of the lease ring: a stamp register loaded from its neighbor
// depends on lcau_pkg
module lcau_cell
    import lcau_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic [STAMP_W-1:0] i_d,
    output logic [STAMP_W-1:0] o_q
);

    logic [STAMP_W-1:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
        end else if (i_shift) begin
            r_stamp <= i_d;
        end
    end

    assign o_q = r_stamp;

endmodule

/* src/lcau_ring.sv */
// ring of slot cells rotating toward cell 0; the head value re-enters at the tail
// depends on lcau_pkg and lcau_cell
module lcau_ring
    import lcau_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ring_ctl          i_ctl,
    output logic [STAMP_W-1:0] o_head
);

    logic [STAMP_W-1:0] w_q [MAX_SLOTS];
    logic [STAMP_W-1:0] w_d [MAX_SLOTS];

    // head value written back, replaced on a grant or a release
    assign w_d[MAX_SLOTS-1] = i_ctl.wr ? i_ctl.data : w_q[0];

    genvar k;
    generate
        for (k = 0; k < MAX_SLOTS - 1; k++) begin : g_link
            assign w_d[k] = w_q[k+1];
        end
        for (k = 0; k < MAX_SLOTS; k++) begin : g_cell
            lcau_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_ctl.shift),
                .i_d     (w_d[k]),
                .o_q     (w_q[k])
            );
        end
    endgenerate

    assign o_head = w_q[0];

endmodule

/* src/lease_credit_allocator_unit.sv */
// lease credit allocator: slot ring plus a one-transaction-at-a-time scan sequencer
// result registered on the last rotation step; that step stalls while the output is full
// a new transaction is accepted only after the full ring rotation of the previous one
// the ring turns once per transaction; the cell 0 slot is checked each unstalled cycle
// reset (synchronous, active low) clears every slot stamp at once, no clearing pass
// depends on lcau_pkg, lcau_ring, lcau_cell and lease_credit_allocator_unit_assert.svh
`include "lease_credit_allocator_unit_assert.svh"

module lease_credit_allocator_unit
    import lcau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [STAMP_W-1:0]   i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // now_seconds[31:0], release_index[41:32]
    input  logic                 s_axis_tuser,   // cmd
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // slot_index[9:0], cookie[41:10]
    output logic                 m_axis_tuser    // granted
);

    // configuration registers
    logic               r_enabled;
    logic [CRED_W-1:0]  r_credits;
    logic [STAMP_W-1:0] r_reclaim;

    // latched request
    logic               r_cmd;
    logic [STAMP_W-1:0] r_now;
    logic [SLOT_W-1:0]  r_rel;

    // scan sequencer
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_step;
    logic               r_found;
    logic [IDX_W-1:0]   r_slot;

    // output register
    logic               r_out_valid;
    logic               r_out_granted;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [STAMP_W-1:0] r_out_cookie;

    t_ring_ctl          w_ctl;
    logic [STAMP_W-1:0] w_head;
    logic [STAMP_W-1:0] w_age;
    logic [LIM_W-1:0]   w_limit;
    logic               w_in_range;
    logic               w_take;
    logic               w_rel_hit;
    logic               w_last;
    logic               w_out_free;
    logic               w_accept;
    logic               w_shift;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_last     = (r_step == IDX_W'(MAX_SLOTS - 1));
    assign w_out_free = !r_out_valid || m_axis_tready;

    // next state; the last rotation step waits for room in the output register
    always_comb begin
        n_state       = r_state;
        w_shift       = 1'b0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!w_last || w_out_free) begin
                    w_shift = 1'b1;
                end
                if (w_last && w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // slot check at the ring head: scan length clamped to the ring size
    assign w_limit    = (LIM_W'(r_credits) > LIM_W'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS)
                                                                 : LIM_W'(r_credits);
    assign w_in_range = (LIM_W'(r_step) < w_limit);
    assign w_age      = r_now - w_head;
    // age must strictly exceed the limit to reclaim
    assign w_take     = (r_cmd == CMD_ACQUIRE) && r_enabled && !r_found && w_in_range &&
                        ((w_head == '0) || (w_age > r_reclaim));
    // release index beyond the ring never matches a step
    assign w_rel_hit  = (r_cmd == CMD_RELEASE) && (LIM_W'(r_step) == LIM_W'(r_rel));

    always_comb begin
        w_ctl.shift = w_shift;
        w_ctl.wr    = w_take || w_rel_hit;
        w_ctl.data  = w_take ? r_now : '0;
    end

    lcau_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_head)
    );

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_credits <= CREDITS_RST;
            r_reclaim <= RECLAIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLED: r_enabled <= i_cfg_data[0];
                CFG_CREDITS: r_credits <= i_cfg_data[CRED_W-1:0];
                CFG_RECLAIM: r_reclaim <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request capture and scan progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_found <= 1'b0;
        end else if (w_accept) begin
            r_step  <= '0;
            r_found <= 1'b0;
        end else if (w_shift) begin
            r_step <= w_last ? '0 : r_step + 1'b1;
            if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= s_axis_tuser;
            r_now <= s_axis_tdata[STAMP_W-1:0];
            r_rel <= s_axis_tdata[STAMP_W +: SLOT_W];
        end
        if (w_shift && w_take) begin
            r_slot <= r_step;
        end
    end

    // result register; loaded when the rotation completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_shift && w_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift && w_last) begin
            if (r_found || w_take) begin
                r_out_granted <= 1'b1;
                r_out_slot    <= SLOT_W'(w_take ? r_step : r_slot);
                r_out_cookie  <= r_now;
            end else begin
                r_out_granted <= 1'b0;
                r_out_slot    <= '0;
                r_out_cookie  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_granted;
    assign m_axis_tdata  = {{(TDATA_W - SLOT_W - STAMP_W){1'b0}}, r_out_cookie, r_out_slot};

    // a stalled last step keeps the ring and the step count where they are
    `LCAU_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n,
        (r_state == ST_SCAN) && w_last && !w_out_free,
        (r_state == ST_SCAN) && w_last, "scan advanced while result register was full")

    // a failed or release result carries zero payload
    `LCAU_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata == '0, "non-granted result with nonzero payload")

    // an accepted transaction starts a scan from slot zero
    `LCAU_ASSERT_NXT(a_scan_start, i_clk, i_rst_n,
        w_accept,
        (r_state == ST_SCAN) && (r_step == '0) && !r_found, "scan did not start at slot zero")

endmodule

/* tb/tb_lease_credit_allocator_unit.sv */
// testbench for lease_credit_allocator_unit: directed and random acquire/release traffic,
// checked against a behavioral copy of the slot table; depends on lcau_pkg and the rtl
`timescale 1ns / 100ps

module tb_lease_credit_allocator_unit;
    import lcau_pkg::*;

    typedef struct packed {
        logic               cmd;
        logic [STAMP_W-1:0] now;
        logic [SLOT_W-1:0]  rel;
    } t_request;

    typedef struct packed {
        logic               granted;
        logic [SLOT_W-1:0]  slot;
        logic [STAMP_W-1:0] cookie;
    } t_grant;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [STAMP_W-1:0]   i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;   // now_seconds[31:0], release_index[41:32]
    logic                 s_axis_tuser = 1'b0; // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;        // slot_index[9:0], cookie[41:10]
    logic                 m_axis_tuser;        // granted

    lease_credit_allocator_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // shadow copy of the slot table and the registers
    logic [STAMP_W-1:0] lease_stamp [MAX_SLOTS];
    logic               shadow_en;
    logic [CRED_W-1:0]  shadow_credits;
    logic [STAMP_W-1:0] shadow_reclaim;

    t_request request_q [$];
    t_grant   grant_q [$];
    t_request tx_item;
    int       tx_gap = 0;
    int       rx_wait = 0;
    int       tx_idle_max = 14;
    int       rx_idle_max = 14;
    int       mismatches = 0;
    int       n_requests = 0;
    int       n_grants = 0;
    int       n_refusals = 0;
    int       n_releases = 0;
    logic [STAMP_W-1:0] wall_s;

    // first-fit scan with reclaim of stale stamps; updates the shadow table
    function automatic t_grant predict_grant(t_request r);
        t_grant       g;
        int unsigned  lim;
        logic [STAMP_W-1:0] age;
        g = '0;
        if (r.cmd == CMD_RELEASE) begin
            // a 10-bit index can never reach past the table, so no out-of-range case here
            if (r.rel < MAX_SLOTS)
                lease_stamp[r.rel] = '0;
            return g;
        end
        if (!shadow_en)
            return g;
        lim = (shadow_credits > MAX_SLOTS) ? MAX_SLOTS : shadow_credits;
        for (int i = 0; i < lim; i++) begin
            age = r.now - lease_stamp[i];
            // age equal to the limit is still a live lease
            if (lease_stamp[i] == '0 || age > shadow_reclaim) begin
                lease_stamp[i] = r.now;
                g.granted = 1'b1;
                g.slot    = i[SLOT_W-1:0];
                g.cookie  = r.now;
                return g;
            end
        end
        return g;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // request driver: one pending transaction at a time, random gap before each
    always @(posedge i_clk) begin : request_driver
        t_request r;
        int       g_draw;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            grant_q.push_back(predict_grant(tx_item));
            n_requests++;
            g_draw = $urandom_range(0, tx_idle_max);
            if (g_draw == 0 && request_q.size() > 0) begin
                r = request_q.pop_front();
                tx_item       <= r;
                s_axis_tdata  <= {{(TDATA_W - STAMP_W - SLOT_W){1'b0}}, r.rel, r.now};
                s_axis_tuser  <= r.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= g_draw;
            end
        end else if (!s_axis_tvalid) begin
            if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
            end else if (request_q.size() > 0) begin
                r = request_q.pop_front();
                tx_item       <= r;
                s_axis_tdata  <= {{(TDATA_W - STAMP_W - SLOT_W){1'b0}}, r.rel, r.now};
                s_axis_tuser  <= r.cmd;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // result monitor: checks each result transaction, then stalls a random count
    always @(posedge i_clk) begin : result_monitor
        t_grant exp_g;
        t_grant act_g;
        int     w_draw;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b1;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            act_g.granted = m_axis_tuser;
            act_g.slot    = m_axis_tdata[SLOT_W-1:0];
            act_g.cookie  = m_axis_tdata[SLOT_W+STAMP_W-1:SLOT_W];
            if (grant_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result granted=%0b slot=%0d cookie=%h",
                                          act_g.granted, act_g.slot, act_g.cookie));
            end else begin
                exp_g = grant_q.pop_front();
                if (act_g.granted != exp_g.granted)
                    report_mismatch($sformatf("granted exp %0b act %0b",
                                              exp_g.granted, act_g.granted));
                if (act_g.slot != exp_g.slot)
                    report_mismatch($sformatf("slot_index exp %0d act %0d",
                                              exp_g.slot, act_g.slot));
                if (act_g.cookie != exp_g.cookie)
                    report_mismatch($sformatf("cookie exp %h act %h",
                                              exp_g.cookie, act_g.cookie));
            end
            if (act_g.granted)
                n_grants++;
            else
                n_refusals++;
            w_draw = $urandom_range(0, rx_idle_max);
            if (w_draw != 0) begin
                m_axis_tready <= 1'b0;
                rx_wait       <= w_draw;
            end
        end else if (m_axis_tvalid && rx_wait != 0) begin
            // stall counts only while a result is actually offered
            rx_wait <= rx_wait - 1;
            if (rx_wait == 1)
                m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_request(logic cmd, logic [STAMP_W-1:0] now, logic [SLOT_W-1:0] rel);
        t_request r;
        r.cmd = cmd;
        r.now = now;
        r.rel = rel;
        if (cmd == CMD_RELEASE)
            n_releases++;
        request_q.push_back(r);
    endtask

    // wait until every queued request is taken and every result is back
    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (request_q.size() != 0 || grant_q.size() != 0 || s_axis_tvalid);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [STAMP_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ENABLED: shadow_en      = data[0];
            CFG_CREDITS: shadow_credits = data[CRED_W-1:0];
            CFG_RECLAIM: shadow_reclaim = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // one random phase: fresh settings, then mostly acquire/release on the scanned region
    task automatic random_phase(int n_items);
        logic [CRED_W-1:0]  cred;
        logic [STAMP_W-1:0] recl;
        logic [STAMP_W-1:0] now;
        int                 span;
        case ($urandom_range(0, 9))
            0: cred = '0;
            1: cred = 11'd1;
            2: cred = 11'd1024;
            3: cred = 11'd2047;
            4: cred = CRED_W'($urandom_range(0, 2047));
            default: cred = CRED_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 7))
            0: recl = '0;
            1: recl = '1;
            2: recl = $urandom;
            default: recl = $urandom_range(1, 40);
        endcase
        // upper write-data bits beyond a register are don't-care
        cfg_write(CFG_ENABLED, {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0,
                                ($urandom_range(0, 7) != 0)});
        cfg_write(CFG_CREDITS, {(STAMP_W-CRED_W)'($urandom), cred});
        cfg_write(CFG_RECLAIM, recl);
        if ($urandom_range(0, 3) == 0) begin
            tx_idle_max = 0;
            rx_idle_max = 0;
        end else begin
            tx_idle_max = 14;
            rx_idle_max = 14;
        end
        span = (cred == 0) ? 4 : ((cred > 16) ? 16 : cred);
        for (int k = 0; k < n_items; k++) begin
            wall_s = wall_s + $urandom_range(0, 6);
            case ($urandom_range(0, 31))
                0:       now = '0;
                1, 2:    now = $urandom;
                default: now = wall_s;
            endcase
            if ($urandom_range(0, 9) < 7)
                queue_request(CMD_ACQUIRE, now, SLOT_W'($urandom));
            else if ($urandom_range(0, 3) != 0)
                queue_request(CMD_RELEASE, $urandom, SLOT_W'($urandom_range(0, span)));
            else
                queue_request(CMD_RELEASE, $urandom, SLOT_W'($urandom));
        end
        wait_quiet();
    endtask

    initial begin
        for (int i = 0; i < MAX_SLOTS; i++)
            lease_stamp[i] = '0;
        shadow_en      = 1'b0;
        shadow_credits = CREDITS_RST;
        shadow_reclaim = RECLAIM_RST;
        wall_s         = $urandom;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: disabled, every acquire refused
        queue_request(CMD_ACQUIRE, 32'd100, '0);
        queue_request(CMD_RELEASE, 32'd0, 10'd5);
        wait_quiet();

        cfg_write(CFG_ENABLED, 32'd1);
        queue_request(CMD_ACQUIRE, 32'd100, '0);
        queue_request(CMD_ACQUIRE, 32'd100, '0);
        // grant at time zero leaves the slot looking free
        queue_request(CMD_ACQUIRE, 32'd0, '0);
        queue_request(CMD_ACQUIRE, 32'd101, '0);
        // slot 1 is exactly at the limit here, then one past it
        queue_request(CMD_ACQUIRE, 32'd108, '0);
        queue_request(CMD_ACQUIRE, 32'd109, '0);
        queue_request(CMD_RELEASE, 32'd0, 10'd1023);
        queue_request(CMD_RELEASE, 32'hffff_ffff, 10'd1);
        queue_request(CMD_ACQUIRE, 32'hffff_ffff, '0);
        // time wrapped below the stored stamps
        queue_request(CMD_ACQUIRE, 32'd5, 10'd1023);
        queue_request(CMD_ACQUIRE, 32'd6, '0);
        wait_quiet();

        // release still clears while disabled
        cfg_write(CFG_ENABLED, 32'd0);
        queue_request(CMD_ACQUIRE, 32'd200, '0);
        queue_request(CMD_RELEASE, 32'd200, 10'd3);
        wait_quiet();
        cfg_write(CFG_ENABLED, 32'd1);
        queue_request(CMD_ACQUIRE, 32'd201, '0);
        wait_quiet();

        // zero scan length
        cfg_write(CFG_CREDITS, 32'd0);
        queue_request(CMD_ACQUIRE, 32'd300, '0);
        wait_quiet();

        // single slot, reclaim at any positive age
        cfg_write(CFG_CREDITS, 32'd1);
        cfg_write(CFG_RECLAIM, 32'd0);
        queue_request(CMD_ACQUIRE, 32'd300, '0);
        queue_request(CMD_ACQUIRE, 32'd300, '0);
        queue_request(CMD_ACQUIRE, 32'd301, '0);
        wait_quiet();

        // scan length past the table is clipped, leases never expire
        cfg_write(CFG_CREDITS, 32'd2047);
        cfg_write(CFG_RECLAIM, 32'hffff_ffff);
        queue_request(CMD_ACQUIRE, 32'd400, '0);
        queue_request(CMD_ACQUIRE, 32'd400, '0);
        queue_request(CMD_RELEASE, 32'd400, 10'd0);
        wait_quiet();

        cfg_write(CFG_CREDITS, 32'd1024);
        cfg_write(CFG_RECLAIM, 32'd8);
        queue_request(CMD_ACQUIRE, 32'd500, '0);
        wait_quiet();

        for (int p = 0; p < 12; p++)
            random_phase(46);

        wait_quiet();
        repeat (1100) @(posedge i_clk);
        if (grant_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", grant_q.size()));

        $display("run covered %0d requests (%0d releases): %0d grants, %0d refusals",
                 n_requests, n_releases, n_grants, n_refusals);
        $display("12 random register settings after the directed cases, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop, several times the slowest expected run
    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* lease_credit_allocator_unit.f */
+incdir+src
src/lcau_pkg.sv
src/lcau_cell.sv
src/lcau_ring.sv
src/lease_credit_allocator_unit.sv
tb/tb_lease_credit_allocator_unit.sv
